@@ hdl/ptmc_pkg.sv @@
// Package for the pinyin tone mark converter.
// Holds the tone key table, the style codes and the controller/datapath
// command and status structs. Depends on nothing.
`default_nettype none

package ptmc_pkg;

  localparam int unsigned MAX_KEY_BYTES = 4;
  localparam int unsigned KEY_COUNT     = 35;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Style codes, sampled at the first byte of a string
  localparam logic [1:0] MODE_STRIP  = 2'd0;
  localparam logic [1:0] MODE_KEEP   = 2'd1;
  localparam logic [1:0] MODE_INLINE = 2'd2;
  localparam logic [1:0] MODE_END    = 2'd3;

  typedef logic [MAX_KEY_BYTES-1:0][7:0] win_t;

  // One entry of the key table; klen of zero means no match
  typedef struct packed {
    logic [2:0]       klen;
    logic [3:0][7:0]  key;
    logic [1:0]       plen;
    logic [1:0][7:0]  plain;
    logic [2:0]       tone;
  } key_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // take the input transaction
    logic decide;      // match at the window head and latch the bytes to send
    logic push_emit;   // send the next latched byte
    logic push_digit;  // send the held digit read from the buffer
    logic finish;      // mark the final byte and clear the string state
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pass_item;      // the offered byte belongs to a keep-marks string
    logic win_full_next;  // window fills with the offered byte
    logic last_item;      // the offered byte ends the string
    logic draining;       // the string has seen its last byte
    logic win_empty;
    logic emit_done;      // all latched bytes sent
    logic flush_done;     // all held digits sent
    logic push_ok;        // the pending byte can move to the output
    logic end_mode;       // digits are held until the end
  } status_t;

  function automatic key_t mk(input logic [2:0] klen,
                              input logic [7:0] k0, input logic [7:0] k1,
                              input logic [7:0] k2, input logic [7:0] k3,
                              input logic [1:0] plen,
                              input logic [7:0] p0, input logic [7:0] p1,
                              input logic [2:0] tone);
    key_t e;
    e.klen     = klen;
    e.key[0]   = k0;
    e.key[1]   = k1;
    e.key[2]   = k2;
    e.key[3]   = k3;
    e.plen     = plen;
    e.plain[0] = p0;
    e.plain[1] = p1;
    e.tone     = tone;
    return e;
  endfunction

  // Tone-marked letters and what they reduce to
  function automatic key_t key_entry(input int k);
    key_t e;
    case (k)
      0:  e = mk(3'd2, 8'hC4, 8'h81, 8'h00, 8'h00, 2'd1, 8'h61, 8'h00, 3'd1);
      1:  e = mk(3'd2, 8'hC3, 8'hA1, 8'h00, 8'h00, 2'd1, 8'h61, 8'h00, 3'd2);
      2:  e = mk(3'd2, 8'hC7, 8'h8E, 8'h00, 8'h00, 2'd1, 8'h61, 8'h00, 3'd3);
      3:  e = mk(3'd2, 8'hC3, 8'hA0, 8'h00, 8'h00, 2'd1, 8'h61, 8'h00, 3'd4);
      4:  e = mk(3'd2, 8'hC4, 8'h93, 8'h00, 8'h00, 2'd1, 8'h65, 8'h00, 3'd1);
      5:  e = mk(3'd2, 8'hC3, 8'hA9, 8'h00, 8'h00, 2'd1, 8'h65, 8'h00, 3'd2);
      6:  e = mk(3'd2, 8'hC4, 8'h9B, 8'h00, 8'h00, 2'd1, 8'h65, 8'h00, 3'd3);
      7:  e = mk(3'd2, 8'hC3, 8'hA8, 8'h00, 8'h00, 2'd1, 8'h65, 8'h00, 3'd4);
      8:  e = mk(3'd2, 8'hC5, 8'h8D, 8'h00, 8'h00, 2'd1, 8'h6F, 8'h00, 3'd1);
      9:  e = mk(3'd2, 8'hC3, 8'hB3, 8'h00, 8'h00, 2'd1, 8'h6F, 8'h00, 3'd2);
      10: e = mk(3'd2, 8'hC7, 8'h92, 8'h00, 8'h00, 2'd1, 8'h6F, 8'h00, 3'd3);
      11: e = mk(3'd2, 8'hC3, 8'hB2, 8'h00, 8'h00, 2'd1, 8'h6F, 8'h00, 3'd4);
      12: e = mk(3'd2, 8'hC4, 8'hAB, 8'h00, 8'h00, 2'd1, 8'h69, 8'h00, 3'd1);
      13: e = mk(3'd2, 8'hC3, 8'hAD, 8'h00, 8'h00, 2'd1, 8'h69, 8'h00, 3'd2);
      14: e = mk(3'd2, 8'hC7, 8'h90, 8'h00, 8'h00, 2'd1, 8'h69, 8'h00, 3'd3);
      15: e = mk(3'd2, 8'hC3, 8'hAC, 8'h00, 8'h00, 2'd1, 8'h69, 8'h00, 3'd4);
      16: e = mk(3'd2, 8'hC5, 8'hAB, 8'h00, 8'h00, 2'd1, 8'h75, 8'h00, 3'd1);
      17: e = mk(3'd2, 8'hC3, 8'hBA, 8'h00, 8'h00, 2'd1, 8'h75, 8'h00, 3'd2);
      18: e = mk(3'd2, 8'hC7, 8'h94, 8'h00, 8'h00, 2'd1, 8'h75, 8'h00, 3'd3);
      19: e = mk(3'd2, 8'hC3, 8'hB9, 8'h00, 8'h00, 2'd1, 8'h75, 8'h00, 3'd4);
      20: e = mk(3'd2, 8'hC7, 8'h96, 8'h00, 8'h00, 2'd1, 8'h76, 8'h00, 3'd1);
      21: e = mk(3'd2, 8'hC7, 8'h98, 8'h00, 8'h00, 2'd1, 8'h76, 8'h00, 3'd2);
      22: e = mk(3'd2, 8'hC7, 8'h9A, 8'h00, 8'h00, 2'd1, 8'h76, 8'h00, 3'd3);
      23: e = mk(3'd2, 8'hC7, 8'h9C, 8'h00, 8'h00, 2'd1, 8'h76, 8'h00, 3'd4);
      24: e = mk(3'd2, 8'hC3, 8'hBC, 8'h00, 8'h00, 2'd1, 8'h76, 8'h00, 3'd0);
      25: e = mk(3'd2, 8'hC5, 8'h84, 8'h00, 8'h00, 2'd1, 8'h6E, 8'h00, 3'd2);
      26: e = mk(3'd2, 8'hC5, 8'h88, 8'h00, 8'h00, 2'd1, 8'h6E, 8'h00, 3'd3);
      27: e = mk(3'd2, 8'hC7, 8'hB9, 8'h00, 8'h00, 2'd1, 8'h6E, 8'h00, 3'd4);
      28: e = mk(3'd3, 8'h6D, 8'hCC, 8'h84, 8'h00, 2'd1, 8'h6D, 8'h00, 3'd1);
      29: e = mk(3'd3, 8'hE1, 8'hB8, 8'hBF, 8'h00, 2'd1, 8'h6D, 8'h00, 3'd2);
      30: e = mk(3'd3, 8'h6D, 8'hCC, 8'h80, 8'h00, 2'd1, 8'h6D, 8'h00, 3'd4);
      31: e = mk(3'd4, 8'hC3, 8'hAA, 8'hCC, 8'h84, 2'd2, 8'hC3, 8'hAA, 3'd1);
      32: e = mk(3'd3, 8'hE1, 8'hBA, 8'hBF, 8'h00, 2'd2, 8'hC3, 8'hAA, 3'd2);
      33: e = mk(3'd4, 8'hC3, 8'hAA, 8'hCC, 8'h8C, 2'd2, 8'hC3, 8'hAA, 3'd3);
      34: e = mk(3'd3, 8'hE1, 8'hBB, 8'h81, 8'h00, 2'd2, 8'hC3, 8'hAA, 3'd4);
      default: e = '0;
    endcase
    return e;
  endfunction

  // Longest key that fits in the filled part of the window; klen zero if none
  function automatic key_t key_match(input win_t win, input logic [2:0] count);
    key_t best;
    key_t e;
    logic ok;
    best = '0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      e  = key_entry(k);
      ok = (e.klen <= count);
      for (int i = 0; i < MAX_KEY_BYTES; i++) begin
        if ((3'(i) < e.klen) && (win[i] != e.key[i])) begin
          ok = 1'b0;
        end
      end
      if (ok && (e.klen > best.klen)) begin
        best = e;
      end
    end
    return best;
  endfunction

endpackage

`default_nettype wire

@@ hdl/ptmc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Used for the held digit buffer. No dependencies.
`default_nettype none

module ptmc_ram #(
  parameter int WIDTH  = 4,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/ptmc_ctrl.sv @@
// Sequencer for the converter: accepts bytes, steps decisions, emits,
// flushes held digits and closes each string. Depends on ptmc_pkg.
`default_nettype none

module ptmc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ptmc_pkg::status_t sts,
  output ptmc_pkg::cmd_t         cmd
);
  import ptmc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_EMIT   = 6'b000100,
    S_RD     = 6'b001000,
    S_DIGIT  = 6'b010000,
    S_FINAL  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.load       = accept;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (sts.pass_item) begin
            state_next = S_EMIT;
          end else if (sts.last_item || sts.win_full_next) begin
            state_next = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.emit_done) begin
          if (!sts.draining) begin
            state_next = S_IDLE;
          end else if (!sts.win_empty) begin
            state_next = S_DECIDE;
          end else if (sts.end_mode) begin
            state_next = S_RD;
          end else begin
            state_next = S_FINAL;
          end
        end else if (sts.push_ok) begin
          cmd.push_emit = 1'b1;
        end
      end
      S_RD: begin
        // buffer read is issued here, data is there next cycle
        state_next = sts.flush_done ? S_FINAL : S_DIGIT;
      end
      S_DIGIT: begin
        if (sts.push_ok) begin
          cmd.push_digit = 1'b1;
          state_next     = S_RD;
        end
      end
      S_FINAL: begin
        if (sts.push_ok) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ptmc_dpath.sv @@
// Datapath of the converter: lookahead window, key match, emit list,
// pending byte, output register and held digit buffer.
// Depends on ptmc_pkg and ptmc_ram.
`default_nettype none

module ptmc_dpath #(
  parameter int DIGIT_DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [7:0]        in_byte,
  input  wire logic [1:0]        mode,
  input  wire logic              in_last,
  input  wire ptmc_pkg::cmd_t    cmd,
  output ptmc_pkg::status_t      sts,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_byte,
  output logic                   out_last,
  output logic                   digit_overflow
);
  import ptmc_pkg::*;

  localparam int AW = (DIGIT_DEPTH > 1) ? $clog2(DIGIT_DEPTH) : 1;
  localparam int CW = $clog2(DIGIT_DEPTH + 1);

  // String state
  win_t        win;
  logic [2:0]  win_count;
  logic [1:0]  active_mode;
  logic        in_string;
  logic        draining;
  logic [CW-1:0] held_count;
  logic [CW-1:0] flush_idx;
  logic        overflow_seen;

  // Latched decision
  logic [2:0][7:0] em_byte;
  logic [1:0]      em_cnt;
  logic [1:0]      em_idx;

  // Pending byte, held back so the final one can be marked
  logic [7:0] pend_byte;
  logic       pend_valid;

  logic [1:0] eff_mode;
  logic       push_ok;
  logic       push_any;
  logic [7:0] push_byte;
  logic       out_load;
  logic [3:0] ram_rdata;

  // Decision at the window head
  key_t            hit;
  logic            hit_any;
  logic [7:0]      tone_char;
  logic [2:0][7:0] dec_byte;
  logic [1:0]      dec_cnt;
  logic [2:0]      dec_used;
  logic            dec_hold;
  logic [3:0]      dec_digit;
  win_t            win_shift;
  logic [2:0]      shift_src;

  assign eff_mode  = in_string ? active_mode : mode;
  assign hit       = key_match(win, win_count);
  assign hit_any   = (hit.klen != 3'd0);
  assign tone_char = CHAR_ZERO + 8'(hit.tone);

  always_comb begin
    dec_byte  = '0;
    dec_cnt   = '0;
    dec_used  = 3'd1;
    dec_hold  = 1'b0;
    dec_digit = '0;
    if (hit_any) begin
      dec_byte[0] = hit.plain[0];
      dec_byte[1] = (hit.plen == 2'd2) ? hit.plain[1] : tone_char;
      dec_byte[2] = tone_char;
      dec_cnt     = hit.plen;
      dec_used    = hit.klen;
      if (hit.tone != 3'd0) begin
        if (active_mode == MODE_END) begin
          dec_hold  = 1'b1;
          dec_digit = {1'b0, hit.tone};
        end else if (active_mode == MODE_INLINE) begin
          dec_cnt = hit.plen + 2'd1;
        end
      end
    end else if ((active_mode == MODE_END) && (win[0] >= CHAR_ZERO) &&
                 (win[0] <= CHAR_NINE)) begin
      dec_hold  = 1'b1;
      dec_digit = win[0][3:0];
    end else begin
      dec_byte[0] = win[0];
      dec_cnt     = 2'd1;
    end
  end

  // Window after dropping the consumed bytes
  always_comb begin
    for (int i = 0; i < MAX_KEY_BYTES; i++) begin
      shift_src    = 3'(i) + dec_used;
      win_shift[i] = (shift_src < 3'(MAX_KEY_BYTES)) ? win[shift_src[1:0]] : 8'h00;
    end
  end

  // Status toward the controller
  assign push_ok  = !pend_valid || !out_valid || !out_stall;
  assign push_any = cmd.push_emit || cmd.push_digit;
  assign push_byte = cmd.push_emit ? em_byte[em_idx] : (CHAR_ZERO + 8'(ram_rdata));
  assign out_load = (push_any || cmd.finish) && pend_valid;

  always_comb begin
    sts               = '0;
    sts.pass_item     = (eff_mode == MODE_KEEP);
    sts.win_full_next = (win_count == 3'(MAX_KEY_BYTES - 1));
    sts.last_item     = in_last;
    sts.draining      = draining;
    sts.win_empty     = (win_count == 3'd0);
    sts.emit_done     = (em_idx == em_cnt);
    sts.flush_done    = (flush_idx == held_count);
    sts.push_ok       = push_ok;
    sts.end_mode      = (active_mode == MODE_END);
  end

  // String control state
  always_ff @(posedge clk) begin
    if (rst) begin
      win_count     <= '0;
      active_mode   <= MODE_STRIP;
      in_string     <= 1'b0;
      draining      <= 1'b0;
      held_count    <= '0;
      flush_idx     <= '0;
      overflow_seen <= 1'b0;
      em_cnt        <= '0;
      em_idx        <= '0;
    end else if (cmd.finish) begin
      win_count     <= '0;
      in_string     <= 1'b0;
      draining      <= 1'b0;
      held_count    <= '0;
      flush_idx     <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cmd.load) begin
        active_mode <= eff_mode;
        in_string   <= 1'b1;
        draining    <= in_last;
        if (eff_mode == MODE_KEEP) begin
          em_cnt <= 2'd1;
          em_idx <= 2'd0;
        end else begin
          win_count <= win_count + 3'd1;
        end
      end
      if (cmd.decide) begin
        win_count <= win_count - dec_used;
        em_cnt    <= dec_cnt;
        em_idx    <= 2'd0;
        if (dec_hold) begin
          if (held_count < CW'(DIGIT_DEPTH)) begin
            held_count <= held_count + CW'(1);
          end else begin
            overflow_seen <= 1'b1;
          end
        end
      end
      if (cmd.push_emit) begin
        em_idx <= em_idx + 2'd1;
      end
      if (cmd.push_digit) begin
        flush_idx <= flush_idx + CW'(1);
      end
    end
  end

  // Window bytes and emit list payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (eff_mode == MODE_KEEP) begin
        em_byte[0] <= in_byte;
      end else begin
        win[win_count[1:0]] <= in_byte;
      end
    end
    if (cmd.decide) begin
      win     <= win_shift;
      em_byte <= dec_byte;
    end
  end

  // Pending byte and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (push_any) begin
        pend_valid <= 1'b1;
      end else if (cmd.finish) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_any) begin
      pend_byte <= push_byte;
    end
    if (out_load) begin
      out_byte       <= pend_byte;
      out_last       <= cmd.finish;
      digit_overflow <= cmd.finish && overflow_seen;
    end
  end

  // Held digit buffer
  ptmc_ram #(
    .WIDTH (4),
    .DEPTH (DIGIT_DEPTH)
  ) u_digits (
    .clk   (clk),
    .we    (cmd.decide && dec_hold && (held_count < CW'(DIGIT_DEPTH))),
    .waddr (held_count[AW-1:0]),
    .wdata (dec_digit),
    .raddr (flush_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

`ifndef NO_ASSERTIONS
  // A byte is never moved onto an output that is still occupied
  a_push_safe: assert property (@(posedge clk) disable iff (rst)
    (cmd.push_emit || cmd.push_digit || cmd.finish) |-> push_ok)
    else $error("push while output register busy");

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CW'(DIGIT_DEPTH))
    else $error("held digit count beyond buffer depth");

  a_win_bound: assert property (@(posedge clk) disable iff (rst)
    win_count <= 3'(MAX_KEY_BYTES))
    else $error("window count beyond key length");

  // Closing a string leaves nothing behind
  a_finish_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (win_count == 3'd0 && !in_string && !pend_valid &&
                    held_count == '0))
    else $error("string state not cleared at finish");
`endif

endmodule

`default_nettype wire

@@ hdl/pinyin_tone_mark_converter_core.sv @@
// Top level of the pinyin tone mark converter: controller plus datapath.
// Depends on ptmc_pkg, ptmc_ctrl, ptmc_dpath (and ptmc_ram below it).
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  in_byte, mode, in_last
//   output   out        out_valid / out_stall out_byte, out_last, digit_overflow
//
// A byte that only fills the lookahead window needs no further step. A byte that
// triggers a decision goes through a decide step and then emit steps for the
// bytes it produces (a keep-marks byte skips the decide step); at the end of a
// string the window drains one decision at a time; in digits-at-end strings the
// held digits then go out, each as a buffer read and then a send, followed by a
// buffer check, and every string ends with a closing step.
// Each output byte is held one step in a pending register so the final one
// can carry out_last; output stalls hold the sequencer, input is stalled
// whenever a transaction is in work. Synchronous reset clears all control.
`default_nettype none

module pinyin_tone_mark_converter_core #(
  parameter int DIGIT_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic [1:0] mode,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            digit_overflow
);
  import ptmc_pkg::*;

  cmd_t    cmd;
  status_t sts;

  ptmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptmc_dpath #(
    .DIGIT_DEPTH (DIGIT_DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .in_byte        (in_byte),
    .mode           (mode),
    .in_last        (in_last),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .digit_overflow (digit_overflow)
  );

endmodule

`default_nettype wire

@@ tb/tb_pinyin_tone_mark_converter_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for pinyin_tone_mark_converter_core: a directed byte table, then
// random pinyin-like strings, checked byte by byte against a behavioral converter.
// Depends on ptmc_pkg and the core RTL; reads no files.
module tb_pinyin_tone_mark_converter_core;
  import ptmc_pkg::*;

  localparam int DIGIT_DEPTH    = 16;
  localparam int RANDOM_BYTES   = 300;
  localparam int QUIET_AFTER    = 260;
  localparam int LONG_HOLD      = 80;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 60;

  // One tone-marked letter: key bytes first-byte-high, plain form, tone number
  typedef struct packed {
    logic [2:0]  klen;
    logic [31:0] key;
    logic [1:0]  plen;
    logic [15:0] plain;
    logic [2:0]  tone;
  } tone_letter_t;

  // One output transaction
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } out_item_t;

  // Directed stimulus row; typed rows carry up to two expected bytes
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] mode;
    logic       last;
    logic       by_model;
    logic [1:0] n_exp;
    logic [7:0] exp0;
    logic [7:0] exp1;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic [1:0] mode;
  logic       in_last;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_last;
  logic       digit_overflow;

  // Converter state mirrored by the testbench
  logic [7:0] win [MAX_KEY_BYTES];
  int         win_cnt = 0;
  logic [1:0] str_mode = MODE_STRIP;
  bit         str_open = 1'b0;
  logic [3:0] held [DIGIT_DEPTH];
  int         held_cnt = 0;
  bit         dropped = 1'b0;

  out_item_t  step_bytes [$];
  out_item_t  converted_bytes [$];

  bit idle_on = 1'b1;
  bit long_hold_req = 1'b0;
  int errors = 0;
  int n_inputs = 0;
  int n_strings = 0;
  int n_results = 0;
  int n_overflow = 0;
  int stuck_cycles = 0;

  pinyin_tone_mark_converter_core #(
    .DIGIT_DEPTH(DIGIT_DEPTH)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .mode          (mode),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .digit_overflow(digit_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Tone-marked letter table
  function automatic tone_letter_t letter_info(input int k);
    tone_letter_t r;
    case (k)
      0:  r = '{3'd2, 32'hC481_0000, 2'd1, 16'h6100, 3'd1};
      1:  r = '{3'd2, 32'hC3A1_0000, 2'd1, 16'h6100, 3'd2};
      2:  r = '{3'd2, 32'hC78E_0000, 2'd1, 16'h6100, 3'd3};
      3:  r = '{3'd2, 32'hC3A0_0000, 2'd1, 16'h6100, 3'd4};
      4:  r = '{3'd2, 32'hC493_0000, 2'd1, 16'h6500, 3'd1};
      5:  r = '{3'd2, 32'hC3A9_0000, 2'd1, 16'h6500, 3'd2};
      6:  r = '{3'd2, 32'hC49B_0000, 2'd1, 16'h6500, 3'd3};
      7:  r = '{3'd2, 32'hC3A8_0000, 2'd1, 16'h6500, 3'd4};
      8:  r = '{3'd2, 32'hC58D_0000, 2'd1, 16'h6F00, 3'd1};
      9:  r = '{3'd2, 32'hC3B3_0000, 2'd1, 16'h6F00, 3'd2};
      10: r = '{3'd2, 32'hC792_0000, 2'd1, 16'h6F00, 3'd3};
      11: r = '{3'd2, 32'hC3B2_0000, 2'd1, 16'h6F00, 3'd4};
      12: r = '{3'd2, 32'hC4AB_0000, 2'd1, 16'h6900, 3'd1};
      13: r = '{3'd2, 32'hC3AD_0000, 2'd1, 16'h6900, 3'd2};
      14: r = '{3'd2, 32'hC790_0000, 2'd1, 16'h6900, 3'd3};
      15: r = '{3'd2, 32'hC3AC_0000, 2'd1, 16'h6900, 3'd4};
      16: r = '{3'd2, 32'hC5AB_0000, 2'd1, 16'h7500, 3'd1};
      17: r = '{3'd2, 32'hC3BA_0000, 2'd1, 16'h7500, 3'd2};
      18: r = '{3'd2, 32'hC794_0000, 2'd1, 16'h7500, 3'd3};
      19: r = '{3'd2, 32'hC3B9_0000, 2'd1, 16'h7500, 3'd4};
      20: r = '{3'd2, 32'hC796_0000, 2'd1, 16'h7600, 3'd1};
      21: r = '{3'd2, 32'hC798_0000, 2'd1, 16'h7600, 3'd2};
      22: r = '{3'd2, 32'hC79A_0000, 2'd1, 16'h7600, 3'd3};
      23: r = '{3'd2, 32'hC79C_0000, 2'd1, 16'h7600, 3'd4};
      24: r = '{3'd2, 32'hC3BC_0000, 2'd1, 16'h7600, 3'd0};
      25: r = '{3'd2, 32'hC584_0000, 2'd1, 16'h6E00, 3'd2};
      26: r = '{3'd2, 32'hC588_0000, 2'd1, 16'h6E00, 3'd3};
      27: r = '{3'd2, 32'hC7B9_0000, 2'd1, 16'h6E00, 3'd4};
      28: r = '{3'd3, 32'h6DCC_8400, 2'd1, 16'h6D00, 3'd1};
      29: r = '{3'd3, 32'hE1B8_BF00, 2'd1, 16'h6D00, 3'd2};
      30: r = '{3'd3, 32'h6DCC_8000, 2'd1, 16'h6D00, 3'd4};
      31: r = '{3'd4, 32'hC3AA_CC84, 2'd2, 16'hC3AA, 3'd1};
      32: r = '{3'd3, 32'hE1BA_BF00, 2'd2, 16'hC3AA, 3'd2};
      33: r = '{3'd4, 32'hC3AA_CC8C, 2'd2, 16'hC3AA, 3'd3};
      34: r = '{3'd3, 32'hE1BB_8100, 2'd2, 16'hC3AA, 3'd4};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic void emit_byte(input logic [7:0] b);
    step_bytes.push_back('{b, 1'b0, 1'b0});
  endfunction

  function automatic void hold_digit(input logic [3:0] v);
    if (held_cnt < DIGIT_DEPTH) begin
      held[held_cnt] = v;
      held_cnt++;
    end else begin
      dropped = 1'b1;
    end
  endfunction

  // Longest letter key at the window head, within the filled bytes; -1 if none
  function automatic int find_longest_key();
    logic [31:0] head;
    logic [31:0] mask;
    tone_letter_t t;
    int len;
    int k;
    head = {win[0], win[1], win[2], win[3]};
    for (len = MAX_KEY_BYTES; len >= 2; len--) begin
      if (len <= win_cnt) begin
        mask = 32'hFFFF_FFFF << (32 - 8 * len);
        for (k = 0; k < KEY_COUNT; k++) begin
          t = letter_info(k);
          if (t.klen == len && (t.key & mask) == (head & mask)) return k;
        end
      end
    end
    return -1;
  endfunction

  // One decision at the window head: rewrite a letter or pass one byte
  function automatic void reduce_window_head();
    tone_letter_t t;
    int k;
    int used;
    int i;
    k = find_longest_key();
    if (k >= 0) begin
      t = letter_info(k);
      emit_byte(t.plain[15:8]);
      if (t.plen == 2) emit_byte(t.plain[7:0]);
      if (t.tone != 0) begin
        if (str_mode == MODE_END) hold_digit(4'(t.tone));
        else if (str_mode == MODE_INLINE) emit_byte(CHAR_ZERO + 8'(t.tone));
      end
      used = t.klen;
    end else begin
      if (str_mode == MODE_END && win[0] >= CHAR_ZERO && win[0] <= CHAR_NINE)
        hold_digit(4'(win[0] - CHAR_ZERO));
      else
        emit_byte(win[0]);
      used = 1;
    end
    for (i = 0; i < MAX_KEY_BYTES; i++) begin
      win[i] = (i + used < MAX_KEY_BYTES) ? win[i + used] : 8'h00;
    end
    win_cnt -= used;
  endfunction

  // Converted bytes caused by one input transaction, into step_bytes
  function automatic void convert_byte(input logic [7:0] b, input logic [1:0] m,
                                       input logic l);
    int i;
    if (!str_open) begin
      str_mode = m;
      str_open = 1'b1;
    end
    if (str_mode == MODE_KEEP) begin
      emit_byte(b);
    end else begin
      win[win_cnt] = b;
      win_cnt++;
      if (l) begin
        while (win_cnt > 0) reduce_window_head();
      end else if (win_cnt >= MAX_KEY_BYTES) begin
        reduce_window_head();
      end
    end
    if (l) begin
      if (str_mode == MODE_END) begin
        for (i = 0; i < held_cnt; i++) emit_byte(CHAR_ZERO + 8'(held[i]));
      end
      if (step_bytes.size() > 0) begin
        step_bytes[step_bytes.size() - 1].last = 1'b1;
        step_bytes[step_bytes.size() - 1].ovf  = dropped;
      end
      win_cnt  = 0;
      held_cnt = 0;
      dropped  = 1'b0;
      str_open = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 40) $display("ERROR at %0t: %s", $time, what);
  endtask

  // Offer one input transaction, wait for it to be taken, then predict its bytes
  task automatic send_item(input logic [7:0] b, input logic [1:0] m, input logic l);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    mode     <= m;
    in_last  <= l;
    do @(posedge clk); while (in_stall);
    n_inputs++;
    if (l) n_strings++;
    step_bytes.delete();
    convert_byte(b, m, l);
  endtask

  // Receiver: random stall bursts, plus one long hold on request
  initial begin : receiver
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        for (n = 1; n < LONG_HOLD; n++) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 5);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Output check and watchdog
  always @(posedge clk) begin : result_check
    out_item_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (converted_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected output byte %02h", out_byte));
        end else begin
          e = converted_bytes.pop_front();
          if (e.ovf) n_overflow++;
          if (out_byte !== e.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, e.data));
          if (out_last !== e.last)
            report_mismatch($sformatf("out_last %b, expected %b (byte %02h)",
                                      out_last, e.last, e.data));
          if (digit_overflow !== e.ovf)
            report_mismatch($sformatf("digit_overflow %b, expected %b (byte %02h)",
                                      digit_overflow, e.ovf, e.data));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles, %0d bytes still expected",
                 stuck_cycles, converted_bytes.size());
        $display("FAIL pinyin_tone_mark_converter_core");
        $finish;
      end
    end
  end

  initial begin : stimulus
    stim_row_t    rows [23];
    out_item_t    e;
    tone_letter_t t;
    logic [7:0]   str [$];
    logic [1:0]   m;
    bit           flood;
    int           ntok;
    int           kind;
    int           cut;
    int           sent;
    int           i;
    int           j;

    rows = '{
      // keep marks: byte extremes pass untouched, mid-string style change ignored
      '{8'h00, MODE_KEEP,   1'b0, 1'b0, 2'd1, 8'h00, 8'h00},
      '{8'hFF, MODE_STRIP,  1'b1, 1'b0, 2'd1, 8'hFF, 8'h00},
      // inline digit: a with acute -> a2
      '{8'hC3, MODE_INLINE, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{8'hA1, MODE_KEEP,   1'b1, 1'b0, 2'd2, 8'h61, 8'h32},
      // strip: three-byte m with acute -> m
      '{8'hE1, MODE_STRIP,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{8'hB8, MODE_END,    1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{8'hBF, MODE_INLINE, 1'b1, 1'b0, 2'd1, 8'h6D, 8'h00},
      // digits at end: four-byte e-circumflex caron, then an input digit
      '{8'hC3, MODE_END,    1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
      '{8'hAA, MODE_STRIP,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
      '{8'hCC, MODE_END,    1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
      '{8'h8C, MODE_END,    1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
      '{8'h37, MODE_END,    1'b1, 1'b1, 2'd0, 8'h00, 8'h00},
      // inline digit: m with grave -> m4
      '{8'h6D, MODE_INLINE, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{8'hCC, MODE_INLINE, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{8'h80, MODE_INLINE, 1'b1, 1'b0, 2'd2, 8'h6D, 8'h34},
      // short tail: string ends on a lone lead byte
      '{8'h61, MODE_STRIP,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
      '{8'hC3, MODE_STRIP,  1'b1, 1'b1, 2'd0, 8'h00, 8'h00},
      // plain u-umlaut carries no tone digit
      '{8'hC3, MODE_INLINE, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{8'hBC, MODE_INLINE, 1'b1, 1'b0, 2'd1, 8'h76, 8'h00},
      // strip: four-byte e-circumflex macron keeps the circumflex
      '{8'hC3, MODE_STRIP,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{8'hAA, MODE_STRIP,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{8'hCC, MODE_STRIP,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{8'h84, MODE_STRIP,  1'b1, 1'b0, 2'd2, 8'hC3, 8'hAA}
    };

    rst      = 1'b1;
    in_valid = 1'b0;
    in_byte  = 8'h00;
    mode     = MODE_STRIP;
    in_last  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    for (i = 0; i < 23; i++) begin
      send_item(rows[i].data, rows[i].mode, rows[i].last);
      if (!rows[i].by_model) begin
        step_bytes.delete();
        for (j = 0; j < rows[i].n_exp; j++) begin
          e.data = (j == 0) ? rows[i].exp0 : rows[i].exp1;
          e.last = rows[i].last && (j == rows[i].n_exp - 1);
          e.ovf  = 1'b0;
          step_bytes.push_back(e);
        end
      end
      converted_bytes = {converted_bytes, step_bytes};
    end

    // Random strings: mostly letters and tone keys, some digits, noise and cut keys
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      str.delete();
      m     = 2'($urandom_range(0, 3));
      flood = (m == MODE_END) && ($urandom_range(0, 2) == 0);
      ntok  = flood ? $urandom_range(14, 20) : $urandom_range(1, 8);
      for (i = 0; i < ntok; i++) begin
        if (flood) str.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        kind = $urandom_range(0, 19);
        if (kind < 8) begin
          t = letter_info($urandom_range(0, KEY_COUNT - 1));
          for (j = 0; j < t.klen; j++) str.push_back(t.key[31 - 8 * j -: 8]);
        end else if (kind < 13) begin
          str.push_back(8'($urandom_range(8'h61, 8'h7A)));
        end else if (kind < 16) begin
          str.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end else if (kind < 18) begin
          str.push_back(8'($urandom_range(0, 255)));
        end else begin
          t   = letter_info($urandom_range(0, KEY_COUNT - 1));
          cut = $urandom_range(1, t.klen - 1);
          for (j = 0; j < cut; j++) str.push_back(t.key[31 - 8 * j -: 8]);
        end
      end
      for (i = 0; i < str.size(); i++) begin
        send_item(str[i], (i == 0) ? m : 2'($urandom_range(0, 3)), i == str.size() - 1);
        converted_bytes = {converted_bytes, step_bytes};
        sent++;
        if (sent == 20) long_hold_req = 1'b1;
        if (sent == QUIET_AFTER) idle_on = 1'b0;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (converted_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d strings, %0d input bytes, %0d output bytes checked.",
             n_strings, n_inputs, n_results);
    $display("%0d strings dropped held digits; %0d mismatches.", n_overflow, errors);
    if (errors == 0) begin
      $display("PASS pinyin_tone_mark_converter_core");
    end else begin
      $display("FAIL pinyin_tone_mark_converter_core");
    end
    $finish;
  end

endmodule

@@ pinyin_tone_mark_converter_core.f @@
hdl/ptmc_pkg.sv
hdl/ptmc_ram.sv
hdl/ptmc_ctrl.sv
hdl/ptmc_dpath.sv
hdl/pinyin_tone_mark_converter_core.sv
tb/tb_pinyin_tone_mark_converter_core.sv
